FILE: hw/rtl/amgd_pkg.sv
// shared types, codes and constants of the motion and gesture detector
package amgd_pkg;

    localparam int LEVEL_W    = 15;
    localparam int DEB_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // queue between classifier and event logic
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;
    // words that can still be in the classifier when the input is stalled
    localparam int Q_SLACK = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_FALL_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROW_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_RMS_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_RMS_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_Z_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_DEBOUNCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_DEBOUNCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_LENGTH = 3'd7;

    // reset values of the registers
    localparam logic [LEVEL_W-1:0] RST_FREE_FALL_LEVEL = 15'd1229;
    localparam logic [LEVEL_W-1:0] RST_THROW_LEVEL     = 15'd6963;
    localparam logic [LEVEL_W-1:0] RST_STILL_RMS_LEVEL = 15'd41;
    localparam logic [LEVEL_W-1:0] RST_SHAKE_RMS_LEVEL = 15'd614;
    localparam logic [LEVEL_W-1:0] RST_SHAKE_Z_LEVEL   = 15'd2867;
    localparam logic [DEB_W-1:0]   RST_ORIENT_DEBOUNCE = 8'd5;
    localparam logic [DEB_W-1:0]   RST_SHAKE_DEBOUNCE  = 8'd2;
    localparam logic [DEB_W-1:0]   RST_SUPPRESS_LENGTH = 8'd2;

    // event codes
    localparam logic [3:0] EV_IDLE         = 4'd0;
    localparam logic [3:0] EV_THROW        = 4'd1;
    localparam logic [3:0] EV_FALL         = 4'd2;
    localparam logic [3:0] EV_UP           = 4'd3;
    localparam logic [3:0] EV_DOWN         = 4'd4;
    localparam logic [3:0] EV_LEFT         = 4'd5;
    localparam logic [3:0] EV_RIGHT        = 4'd6;
    localparam logic [3:0] EV_FORWARD      = 4'd7;
    localparam logic [3:0] EV_BACK         = 4'd8;
    localparam logic [3:0] EV_SHAKE_UD     = 4'd9;
    localparam logic [3:0] EV_SHAKE_UD_INV = 4'd10;
    localparam logic [3:0] EV_SHAKE_LR     = 4'd11;
    localparam logic [3:0] EV_SHAKE_FB     = 4'd12;

    localparam logic [3:0] ORIENT_EV [6] = '{EV_UP, EV_DOWN, EV_LEFT, EV_RIGHT,
                                            EV_FORWARD, EV_BACK};

    // weight classes
    localparam logic [1:0] WC_OVER   = 2'd0;
    localparam logic [1:0] WC_NORMAL = 2'd1;
    localparam logic [1:0] WC_LIGHT  = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] free_fall_level;
        logic [LEVEL_W-1:0] throw_level;
        logic [LEVEL_W-1:0] still_rms_level;
        logic [LEVEL_W-1:0] shake_rms_level;
        logic [LEVEL_W-1:0] shake_z_level;
        logic [DEB_W-1:0]   orient_debounce;
        logic [DEB_W-1:0]   shake_debounce;
        logic [DEB_W-1:0]   suppress_length;
    } cfg_t;

    // classified sample, one word per accepted input
    typedef struct packed {
        logic       z_dom;
        logic       x_dom;
        logic       y_dom;
        logic       over;
        logic       light;
        logic       still;
        logic       shaking;
        logic [5:0] orient;   // up, down, left, right, forward, back
        logic       z_high;
        logic       z_low;
    } cls_t;

endpackage

FILE: hw/rtl/accel_motion_gesture_detector.sv
// top level of the accelerometer motion and gesture detector
//
// Input channel: in_valid/in_stall with accel_x, accel_y, accel_z (signed,
// SAMPLE_BITS wide). A word is taken at a clock edge with in_valid high and
// in_stall low. Output channel: out_valid/out_stall with event_code and
// weight_status, exactly one result word per input word, in order.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no word is in flight.
// An accepted word passes classifier stages one and two, the queue write and
// the event stage register. Throughput: one word per cycle while in_stall is
// low, set by the gravity estimate update, the classifier's only feedback loop.
// The classifier feeds an 8-word queue; in_stall rises when the queue holds
// five or more words, so a stalled receiver backs up into the queue first.
// While out_stall is high the result word holds steady and input words keep
// flowing until the queue holds five words.
// Reset (rst_n low, asynchronous) clears gravity estimate, counters and
// queue, sets weight class to normal and loads register defaults.
module accel_motion_gesture_detector #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [SAMPLE_BITS-1:0]            accel_x,
    input  logic signed [SAMPLE_BITS-1:0]            accel_y,
    input  logic signed [SAMPLE_BITS-1:0]            accel_z,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [3:0]                               event_code,
    output logic [1:0]                               weight_status,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [amgd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [amgd_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import amgd_pkg::*;

    cfg_t cfg_reg;
    logic accept;
    logic push;
    cls_t push_word;
    logic pop;
    cls_t pop_word;
    logic q_valid;
    logic almost_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.free_fall_level <= RST_FREE_FALL_LEVEL;
            cfg_reg.throw_level     <= RST_THROW_LEVEL;
            cfg_reg.still_rms_level <= RST_STILL_RMS_LEVEL;
            cfg_reg.shake_rms_level <= RST_SHAKE_RMS_LEVEL;
            cfg_reg.shake_z_level   <= RST_SHAKE_Z_LEVEL;
            cfg_reg.orient_debounce <= RST_ORIENT_DEBOUNCE;
            cfg_reg.shake_debounce  <= RST_SHAKE_DEBOUNCE;
            cfg_reg.suppress_length <= RST_SUPPRESS_LENGTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FREE_FALL_LEVEL: cfg_reg.free_fall_level <= cfg_data[LEVEL_W-1:0];
                CFG_THROW_LEVEL:     cfg_reg.throw_level     <= cfg_data[LEVEL_W-1:0];
                CFG_STILL_RMS_LEVEL: cfg_reg.still_rms_level <= cfg_data[LEVEL_W-1:0];
                CFG_SHAKE_RMS_LEVEL: cfg_reg.shake_rms_level <= cfg_data[LEVEL_W-1:0];
                CFG_SHAKE_Z_LEVEL:   cfg_reg.shake_z_level   <= cfg_data[LEVEL_W-1:0];
                CFG_ORIENT_DEBOUNCE: cfg_reg.orient_debounce <= cfg_data[DEB_W-1:0];
                CFG_SHAKE_DEBOUNCE:  cfg_reg.shake_debounce  <= cfg_data[DEB_W-1:0];
                CFG_SUPPRESS_LENGTH: cfg_reg.suppress_length <= cfg_data[DEB_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_stall = almost_full;
    assign accept   = in_valid && !in_stall;

    amgd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .cfg       (cfg_reg),
        .push      (push),
        .push_word (push_word)
    );

    amgd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_word   (push_word),
        .pop         (pop),
        .pop_word    (pop_word),
        .q_valid     (q_valid),
        .almost_full (almost_full)
    );

    amgd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_word        (pop_word),
        .pop           (pop),
        .cfg           (cfg_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_code    (event_code),
        .weight_status (weight_status)
    );

endmodule

FILE: hw/rtl/amgd_front.sv
// classifier: gravity estimate, residuals, squared sums and threshold compares
module amgd_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] accel_x,
    input  logic signed [SAMPLE_BITS-1:0] accel_y,
    input  logic signed [SAMPLE_BITS-1:0] accel_z,
    input  amgd_pkg::cfg_t                cfg,
    output logic                          push,
    output amgd_pkg::cls_t                push_word
);
    import amgd_pkg::*;

    localparam int FRAC_BITS = SAMPLE_BITS - 4;
    localparam int SQ_W      = 2 * SAMPLE_BITS + 2;
    localparam int CMP_W     = (SQ_W > 32) ? SQ_W : 32;
    localparam int ZC_W      = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;
    localparam int ONE_G     = 1 << FRAC_BITS;

    localparam logic signed [SAMPLE_BITS:0] Z_HI = (SAMPLE_BITS+1)'((107 * ONE_G) / 100);
    localparam logic signed [SAMPLE_BITS:0] Z_LO = (SAMPLE_BITS+1)'(-((94 * ONE_G) / 100));
    localparam logic signed [SAMPLE_BITS:0] X_HI = (SAMPLE_BITS+1)'((98 * ONE_G) / 100);
    localparam logic signed [SAMPLE_BITS:0] X_LO = (SAMPLE_BITS+1)'(-((100 * ONE_G) / 100));
    localparam logic signed [SAMPLE_BITS:0] Y_HI = (SAMPLE_BITS+1)'((100 * ONE_G) / 100);
    localparam logic signed [SAMPLE_BITS:0] Y_LO = (SAMPLE_BITS+1)'(-((98 * ONE_G) / 100));

    // stage 1: gravity update and residual
    logic signed [SAMPLE_BITS-1:0] grav_reg [3];
    logic signed [SAMPLE_BITS-1:0] a1_reg [3];
    logic signed [SAMPLE_BITS-1:0] g1_reg [3];
    logic signed [SAMPLE_BITS:0]   r1_reg [3];
    logic                          v1_reg;

    logic signed [SAMPLE_BITS-1:0] a_in [3];
    logic signed [SAMPLE_BITS:0]   g_sum [3];
    logic signed [SAMPLE_BITS-1:0] g_next [3];
    logic signed [SAMPLE_BITS:0]   r_next [3];

    assign a_in[0] = accel_x;
    assign a_in[1] = accel_y;
    assign a_in[2] = accel_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g_sum[i]  = {grav_reg[i][SAMPLE_BITS-1], grav_reg[i]}
                      + {a_in[i][SAMPLE_BITS-1], a_in[i]};
            // dropping the lsb of the sum is floor of half
            g_next[i] = g_sum[i][SAMPLE_BITS:1];
            r_next[i] = {a_in[i][SAMPLE_BITS-1], a_in[i]}
                      - {g_next[i][SAMPLE_BITS-1], g_next[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                grav_reg[i] <= '0;
            end
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            if (accept)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    grav_reg[i] <= g_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= a_in[i];
                g1_reg[i] <= g_next[i];
                r1_reg[i] <= r_next[i];
            end
        end
    end

    // stage 2: squares, sums and dominant axis
    logic signed [SQ_W-1:0]      r_sq [3];
    logic signed [SQ_W-1:0]      a_sq [3];
    logic [SAMPLE_BITS:0]        r_abs [3];
    logic signed [SQ_W-1:0]      rsq_sum;
    logic signed [SQ_W-1:0]      msq_sum;

    logic [SQ_W-1:0]             rsq2_reg;
    logic [SQ_W-1:0]             msq2_reg;
    logic                        z_dom2_reg;
    logic                        x_dom2_reg;
    logic                        y_dom2_reg;
    logic signed [SAMPLE_BITS-1:0] g2_reg [3];
    logic signed [SAMPLE_BITS-1:0] az2_reg;
    logic                        v2_reg;

    always_comb
    begin
        rsq_sum = '0;
        msq_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            r_sq[i]  = r1_reg[i] * r1_reg[i];
            a_sq[i]  = a1_reg[i] * a1_reg[i];
            r_abs[i] = r1_reg[i][SAMPLE_BITS] ? unsigned'(-r1_reg[i]) : unsigned'(r1_reg[i]);
            rsq_sum  = rsq_sum + r_sq[i];
            msq_sum  = msq_sum + a_sq[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            rsq2_reg   <= unsigned'(rsq_sum);
            msq2_reg   <= unsigned'(msq_sum);
            z_dom2_reg <= (r_abs[2] > r_abs[0]) && (r_abs[2] > r_abs[1]);
            x_dom2_reg <= (r_abs[0] > r_abs[2]) && (r_abs[0] > r_abs[1]);
            y_dom2_reg <= (r_abs[1] > r_abs[2]) && (r_abs[1] > r_abs[0]);
            az2_reg    <= a1_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                g2_reg[i] <= g1_reg[i];
            end
        end
    end

    // squared thresholds, the rms ones times three, refreshed every cycle from the registers
    logic [2*LEVEL_W-1:0] ff_prod;
    logic [2*LEVEL_W-1:0] throw_prod;
    logic [2*LEVEL_W-1:0] still_prod;
    logic [2*LEVEL_W-1:0] shake_prod;
    logic [CMP_W-1:0]     ff_sq_reg;
    logic [CMP_W-1:0]     throw_sq_reg;
    logic [CMP_W-1:0]     still_sq3_reg;
    logic [CMP_W-1:0]     shake_sq3_reg;

    assign ff_prod    = cfg.free_fall_level * cfg.free_fall_level;
    assign throw_prod = cfg.throw_level * cfg.throw_level;
    assign still_prod = cfg.still_rms_level * cfg.still_rms_level;
    assign shake_prod = cfg.shake_rms_level * cfg.shake_rms_level;

    always_ff @(posedge clk)
    begin
        ff_sq_reg     <= CMP_W'(ff_prod);
        throw_sq_reg  <= CMP_W'(throw_prod);
        still_sq3_reg <= CMP_W'(still_prod) + CMP_W'({still_prod, 1'b0});
        shake_sq3_reg <= CMP_W'(shake_prod) + CMP_W'({shake_prod, 1'b0});
    end

    // stage 3: compares, word goes to the queue
    logic [CMP_W-1:0]              rsq_e;
    logic [CMP_W-1:0]              msq_e;
    logic signed [SAMPLE_BITS:0]   gx_e;
    logic signed [SAMPLE_BITS:0]   gy_e;
    logic signed [SAMPLE_BITS:0]   gz_e;
    logic signed [ZC_W-1:0]        az_e;
    logic signed [ZC_W-1:0]        zlvl_e;

    assign rsq_e  = CMP_W'(rsq2_reg);
    assign msq_e  = CMP_W'(msq2_reg);
    assign gx_e   = {g2_reg[0][SAMPLE_BITS-1], g2_reg[0]};
    assign gy_e   = {g2_reg[1][SAMPLE_BITS-1], g2_reg[1]};
    assign gz_e   = {g2_reg[2][SAMPLE_BITS-1], g2_reg[2]};
    assign az_e   = ZC_W'(az2_reg);
    assign zlvl_e = signed'(ZC_W'(cfg.shake_z_level));

    always_comb
    begin
        push_word.z_dom     = z_dom2_reg;
        push_word.x_dom     = x_dom2_reg;
        push_word.y_dom     = y_dom2_reg;
        push_word.over      = msq_e > throw_sq_reg;
        push_word.light     = msq_e < ff_sq_reg;
        push_word.still     = rsq_e < still_sq3_reg;
        push_word.shaking   = rsq_e >= shake_sq3_reg;
        push_word.orient[0] = gz_e > Z_HI;
        push_word.orient[1] = gz_e < Z_LO;
        push_word.orient[2] = gx_e > X_HI;
        push_word.orient[3] = gx_e < X_LO;
        push_word.orient[4] = gy_e > Y_HI;
        push_word.orient[5] = gy_e < Y_LO;
        push_word.z_high    = az_e > zlvl_e;
        push_word.z_low     = az_e < -zlvl_e;
    end

    assign push = v2_reg;

endmodule

FILE: hw/rtl/amgd_queue.sv
// short queue of classified words between classifier and event logic
module amgd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  amgd_pkg::cls_t push_word,
    input  logic           pop,
    output amgd_pkg::cls_t pop_word,
    output logic           q_valid,
    output logic           almost_full
);
    import amgd_pkg::*;

    cls_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign pop_word = mem_reg[rd_ptr_reg];
    assign q_valid  = count_reg != '0;
    // room is kept for every word still inside the classifier
    assign almost_full = count_reg >= Q_CNT_W'(Q_DEPTH - Q_SLACK);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < Q_CNT_W'(Q_DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        almost_full |=> count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/amgd_back.sv
// event logic: debounce counters, priorities, suppression and output register
module amgd_back #(
    parameter int COUNT_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  amgd_pkg::cls_t q_word,
    output logic           pop,
    input  amgd_pkg::cfg_t cfg,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [3:0]     event_code,
    output logic [1:0]     weight_status
);
    import amgd_pkg::*;

    localparam int DC_W = (COUNT_BITS > DEB_W) ? COUNT_BITS : DEB_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic meets(input logic [COUNT_BITS-1:0] c,
                                   input logic [DEB_W-1:0] deb);
        return DC_W'(c) >= DC_W'(deb);
    endfunction

    logic [COUNT_BITS-1:0] tc_reg, tc_next;
    logic [COUNT_BITS-1:0] fc_reg, fc_next;
    logic [COUNT_BITS-1:0] oc_reg [6];
    logic [COUNT_BITS-1:0] oc_next [6];
    logic [COUNT_BITS-1:0] sc_reg [3];
    logic [COUNT_BITS-1:0] sc_next [3];
    logic [DEB_W-1:0]      sup_reg, sup_next;
    logic [1:0]            wc_reg, wc_next;
    logic [3:0]            ev_next;
    logic                  out_valid_reg;
    logic [3:0]            ev_reg;
    logic [1:0]            ws_reg;

    logic                  done;
    logic                  orient_hit;
    logic                  shake_hit;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        tc_next    = tc_reg;
        fc_next    = fc_reg;
        sup_next   = sup_reg;
        wc_next    = wc_reg;
        ev_next    = EV_IDLE;
        done       = 1'b0;
        orient_hit = 1'b0;
        shake_hit  = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            oc_next[i] = oc_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            sc_next[i] = sc_reg[i];
        end

        // weight class, only when z carries the largest residual
        if (q_word.z_dom)
        begin
            if (q_word.over)
            begin
                wc_next = WC_OVER;
                tc_next = sat_inc(tc_reg);
                fc_next = '0;
            end
            else if (q_word.light)
            begin
                wc_next = WC_LIGHT;
                fc_next = sat_inc(fc_reg);
            end
            else
            begin
                wc_next = WC_NORMAL;
                tc_next = '0;
                fc_next = '0;
            end
        end

        if (fc_next != '0)
        begin
            ev_next  = (tc_next != '0) ? EV_THROW : EV_FALL;
            sup_next = cfg.suppress_length;
            tc_next  = '0;
            fc_next  = '0;
            done     = 1'b1;
        end

        if (!done)
        begin
            if (q_word.still)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    oc_next[i] = q_word.orient[i] ? sat_inc(oc_reg[i]) : '0;
                end
            end
            for (int i = 0; i < 6; i++)
            begin
                if (!orient_hit && meets(oc_next[i], cfg.orient_debounce))
                begin
                    orient_hit = 1'b1;
                    ev_next    = ORIENT_EV[i];
                end
            end
            if (orient_hit)
            begin
                sup_next = cfg.suppress_length;
                for (int i = 0; i < 6; i++)
                begin
                    oc_next[i] = '0;
                end
                done = 1'b1;
            end
        end

        if (!done)
        begin
            if (sup_reg != '0)
            begin
                sup_next = sup_reg - 1'b1;
            end
            else if (!q_word.shaking)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sc_next[i] = '0;
                end
            end
            else
            begin
                if (q_word.z_dom)
                begin
                    sc_next[0] = sat_inc(sc_reg[0]);
                    sc_next[1] = '0;
                    sc_next[2] = '0;
                end
                else if (q_word.x_dom)
                begin
                    sc_next[0] = '0;
                    sc_next[1] = sat_inc(sc_reg[1]);
                    sc_next[2] = '0;
                end
                else if (q_word.y_dom)
                begin
                    sc_next[0] = '0;
                    sc_next[1] = '0;
                    sc_next[2] = sat_inc(sc_reg[2]);
                end

                shake_hit = 1'b1;
                if (meets(sc_next[0], cfg.shake_debounce))
                begin
                    // up-down shake needs raw z clearly off center
                    if (q_word.z_high)
                    begin
                        ev_next = EV_SHAKE_UD;
                    end
                    else if (q_word.z_low)
                    begin
                        ev_next = EV_SHAKE_UD_INV;
                    end
                end
                else if (meets(sc_next[1], cfg.shake_debounce))
                begin
                    ev_next = EV_SHAKE_LR;
                end
                else if (meets(sc_next[2], cfg.shake_debounce))
                begin
                    ev_next = EV_SHAKE_FB;
                end
                else
                begin
                    shake_hit = 1'b0;
                end
                if (shake_hit)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sc_next[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg        <= '0;
            fc_reg        <= '0;
            sup_reg       <= '0;
            wc_reg        <= WC_NORMAL;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                oc_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                sc_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                tc_reg  <= tc_next;
                fc_reg  <= fc_next;
                sup_reg <= sup_next;
                wc_reg  <= wc_next;
                for (int i = 0; i < 6; i++)
                begin
                    oc_reg[i] <= oc_next[i];
                end
                for (int i = 0; i < 3; i++)
                begin
                    sc_reg[i] <= sc_next[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg <= ev_next;
            ws_reg <= wc_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_code    = ev_reg;
    assign weight_status = ws_reg;

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ev_reg <= EV_SHAKE_FB)
        else $error("event code out of range");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ws_reg == WC_OVER || ws_reg == WC_NORMAL || ws_reg == WC_LIGHT))
        else $error("weight status out of range");

    a_suppress_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (ev_next == EV_THROW || ev_next == EV_FALL)
            |=> sup_reg == $past(cfg.suppress_length) && tc_reg == '0 && fc_reg == '0)
        else $error("throw or fall did not arm suppression");

endmodule
